FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the mosaic block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by a result on the next edge.
`define ASSERT_NEXT(label, clk, rst, cond, res, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) else $error(msg);

`endif

FILE: src/mbm_pkg.sv
// ----------------------------------------------------------------------------
// mbm_pkg
// Types and constants shared by the masked block mosaic modules.
// ----------------------------------------------------------------------------
package mbm_pkg;

   localparam int BLOCK_SIZE_DEF = 10;
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int ROW_LIMIT      = 4096;
   localparam int ROW_W          = 12;
   localparam int CFG_W          = 13;
   localparam int CSR_IDX_W      = 1;
   localparam int STORE_W        = 25;

   localparam logic [CFG_W-1:0]     WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0]     HEIGHT_RESET = 13'd480;
   localparam logic [7:0]           MASK_FULL    = 8'd255;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 1'd1;

   typedef struct packed {
      logic [7:0] chan0;
      logic [7:0] chan1;
      logic [7:0] chan2;
      logic [7:0] mask_value;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] out_chan0;
      logic [7:0] out_chan1;
      logic [7:0] out_chan2;
      logic       was_replaced;
   } pixel_out_type;

   typedef struct packed {
      logic part;
      logic corner;
   } tile_ctl_type;

endpackage

FILE: src/masked_block_mosaic.sv
// ----------------------------------------------------------------------------
// masked_block_mosaic
// Block pixelation of a raster pixel stream where the tile corner mask is full.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Word
// req       in   req_valid/stall    pixel_in_type (3 channels + mask byte)
// rsp       out  rsp_valid/stall    pixel_out_type (3 channels + replaced flag)
// csr       in   csr_write_en       csr_index selects width or height
//
// One pixel per clock while rsp_stall stays low; registered at the store read and the output reg.
// The tile store is read at the tile column for every accepted pixel and
// written only at tile corners.
// Reset clears counters and valids; store contents stay undefined until a
// corner pixel writes them. req_stall rises only while both the lookup stage
// and the output register hold words and rsp_stall is high.
// ----------------------------------------------------------------------------
module masked_block_mosaic #(
   parameter int BLOCK_SIZE = mbm_pkg::BLOCK_SIZE_DEF,
   parameter int MAX_WIDTH  = mbm_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mbm_pkg::pixel_in_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mbm_pkg::pixel_out_type        rsp_word,
   input  logic                          csr_write_en,
   input  logic [mbm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mbm_pkg::CFG_W-1:0]     csr_wdata
);
   import mbm_pkg::*;

   localparam int TILE_DEPTH = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int IDX_W      = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;

   logic [CFG_W-1:0]   width_ff, height_ff;
   logic               req_accept;
   tile_ctl_type       ctl;
   logic [IDX_W-1:0]   tile_index;
   logic [STORE_W-1:0] wr_data, rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_accept = req_valid && !req_stall;
   assign wr_data = {(req_word.mask_value == MASK_FULL),
                     req_word.chan2, req_word.chan1, req_word.chan0};

   mbm_pos #(
      .BLOCK_SIZE (BLOCK_SIZE),
      .MAX_WIDTH  (MAX_WIDTH),
      .TILE_DEPTH (TILE_DEPTH),
      .IDX_W      (IDX_W)
   ) u_pos (
      .clock      (clock),
      .reset      (reset),
      .advance    (req_accept),
      .img_width  (width_ff),
      .img_height (height_ff),
      .ctl        (ctl),
      .tile_index (tile_index)
   );

   mbm_store #(
      .TILE_DEPTH (TILE_DEPTH),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept && ctl.part && ctl.corner),
      .wr_addr (tile_index),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (tile_index),
      .rd_data (rd_data)
   );

   mbm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_word   (req_word),
      .in_ctl    (ctl),
      .rd_data   (rd_data),
      .rsp_stall (rsp_stall),
      .in_stall  (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: src/mbm_pos.sv
// ----------------------------------------------------------------------------
// mbm_pos
// Raster position and tile origin counters; flags tile membership and corner.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbm_pos #(
   parameter int BLOCK_SIZE = mbm_pkg::BLOCK_SIZE_DEF,
   parameter int MAX_WIDTH  = mbm_pkg::MAX_WIDTH_DEF,
   parameter int TILE_DEPTH = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE,
   parameter int IDX_W      = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [mbm_pkg::CFG_W-1:0]  img_width,
   input  logic [mbm_pkg::CFG_W-1:0]  img_height,
   output mbm_pkg::tile_ctl_type      ctl,
   output logic [IDX_W-1:0]           tile_index
);
   import mbm_pkg::*;

   localparam int POS_W = $clog2(MAX_WIDTH);
   localparam int PH_W  = $clog2(BLOCK_SIZE);
   localparam int EW    = CFG_W + 2;

   logic [POS_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PH_W-1:0]  col_ph_ff, col_ph_in;
   logic [PH_W-1:0]  row_ph_ff, row_ph_in;
   logic [IDX_W-1:0] tile_idx_ff, tile_idx_in;
   logic [POS_W-1:0] tile_col_ff, tile_col_in;
   logic [ROW_W-1:0] tile_row_ff, tile_row_in;

   logic [EW-1:0] eff_w, eff_h;
   logic          col_wrap, row_wrap;

   always_comb begin
      eff_w = (EW'(img_width) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(img_width);
      eff_h = (EW'(img_height) > EW'(ROW_LIMIT)) ? EW'(ROW_LIMIT) : EW'(img_height);
      col_wrap = (EW'(col_ff) + EW'(1)) >= eff_w;
      row_wrap = (EW'(row_ff) + EW'(1)) >= eff_h;
      ctl.part = ((EW'(tile_col_ff) + EW'(BLOCK_SIZE)) < eff_w) &&
                 ((EW'(tile_row_ff) + EW'(BLOCK_SIZE)) < eff_h);
      ctl.corner = (col_ph_ff == '0) && (row_ph_ff == '0);
      tile_index = tile_idx_ff;
   end

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      col_ph_in   = col_ph_ff;
      row_ph_in   = row_ph_ff;
      tile_idx_in = tile_idx_ff;
      tile_col_in = tile_col_ff;
      tile_row_in = tile_row_ff;
      if (advance) begin
         if (col_wrap) begin
            col_in      = '0;
            col_ph_in   = '0;
            tile_col_in = '0;
            tile_idx_in = '0;
            if (row_wrap) begin
               row_in      = '0;
               row_ph_in   = '0;
               tile_row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
               if ((PH_W+1)'(row_ph_ff) + (PH_W+1)'(1) == (PH_W+1)'(BLOCK_SIZE)) begin
                  row_ph_in   = '0;
                  tile_row_in = row_ff + ROW_W'(1);
               end else begin
                  row_ph_in = row_ph_ff + PH_W'(1);
               end
            end
         end else begin
            col_in = col_ff + POS_W'(1);
            if ((PH_W+1)'(col_ph_ff) + (PH_W+1)'(1) == (PH_W+1)'(BLOCK_SIZE)) begin
               col_ph_in   = '0;
               tile_col_in = col_ff + POS_W'(1);
               tile_idx_in = tile_idx_ff + IDX_W'(1);
            end else begin
               col_ph_in = col_ph_ff + PH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         col_ph_ff   <= '0;
         row_ph_ff   <= '0;
         tile_idx_ff <= '0;
         tile_col_ff <= '0;
         tile_row_ff <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         col_ph_ff   <= col_ph_in;
         row_ph_ff   <= row_ph_in;
         tile_idx_ff <= tile_idx_in;
         tile_col_ff <= tile_col_in;
         tile_row_ff <= tile_row_in;
      end
   end

   `ASSERT_ALWAYS(a_idx_range, clock, reset, (32'(tile_idx_ff) < TILE_DEPTH), "tile index beyond store")
   `ASSERT_ALWAYS(a_phase_range, clock, reset, ((32'(col_ph_ff) < BLOCK_SIZE) && (32'(row_ph_ff) < BLOCK_SIZE)), "tile phase out of range")
   `ASSERT_NEXT(a_row_wrap, clock, reset, (advance && col_wrap), ((col_ff == '0) && (tile_idx_ff == '0) && (tile_col_ff == '0)), "line end did not clear column state")

endmodule

FILE: src/mbm_store.sv
// ----------------------------------------------------------------------------
// mbm_store
// Line store of tile corner colours and mosaic flags, one entry per tile column.
// ----------------------------------------------------------------------------
module mbm_store #(
   parameter int TILE_DEPTH = 410,
   parameter int IDX_W      = 9
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [mbm_pkg::STORE_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [mbm_pkg::STORE_W-1:0]  rd_data
);
   import mbm_pkg::*;

   logic [STORE_W-1:0] tile_store_ff [TILE_DEPTH];
   logic [STORE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tile_store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tile_store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/mbm_out.sv
// ----------------------------------------------------------------------------
// mbm_out
// Lookup stage and output register: picks corner colour or pass-through.
// ----------------------------------------------------------------------------
module mbm_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_accept,
   input  mbm_pkg::pixel_in_type        in_word,
   input  mbm_pkg::tile_ctl_type        in_ctl,
   input  logic [mbm_pkg::STORE_W-1:0]  rd_data,
   input  logic                         rsp_stall,
   output logic                         in_stall,
   output logic                         rsp_valid,
   output mbm_pkg::pixel_out_type       rsp_word
);
   import mbm_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   pixel_in_type  s1_word_ff;
   tile_ctl_type  s1_ctl_ff;
   logic          out_valid_ff, out_valid_in;
   pixel_out_type out_word_ff, out_word_in;
   logic          s1_move;
   logic          use_store;

   always_comb begin
      s1_move      = s1_valid_ff && (!out_valid_ff || !rsp_stall);
      in_stall     = s1_valid_ff && !s1_move;
      s1_valid_in  = in_accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);

      use_store = s1_ctl_ff.part && !s1_ctl_ff.corner && rd_data[STORE_W-1];
      if (use_store) begin
         out_word_in.out_chan0 = rd_data[7:0];
         out_word_in.out_chan1 = rd_data[15:8];
         out_word_in.out_chan2 = rd_data[23:16];
      end else begin
         out_word_in.out_chan0 = s1_word_ff.chan0;
         out_word_in.out_chan1 = s1_word_ff.chan1;
         out_word_in.out_chan2 = s1_word_ff.chan2;
      end
      out_word_in.was_replaced = use_store ||
         (s1_ctl_ff.part && s1_ctl_ff.corner && (s1_word_ff.mask_value == MASK_FULL));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (in_accept) begin
         s1_word_ff <= in_word;
         s1_ctl_ff  <= in_ctl;
      end
      if (s1_move) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
